@@ rtl/dqp_pkg.sv @@
// Package for the DNS question parser: sizes, codes, states and link structs.
package dqp_pkg;

  // Message store size and derived widths
  localparam int MSG_BYTES      = 512;
  localparam int ADDR_W         = $clog2(MSG_BYTES);
  // Positions hold any 14-bit pointer target and the store size itself
  localparam int POS_W          = (ADDR_W + 1 > 15) ? ADDR_W + 1 : 15;
  localparam int MAX_HOPS       = 16;
  localparam int HOP_W          = 5;
  localparam int MAX_NAME_CHARS = 255;
  localparam int LEN_W          = 8;

  // Item field widths
  localparam int OFFSET_W = 9;
  localparam int BYTE_W   = 8;
  localparam int CHARS_W  = 64;
  localparam int COUNT_W  = 4;
  localparam int QWORD_W  = 16;
  localparam int NEXT_W   = 10;
  localparam int ERR_W    = 2;

  // Wire-format constants
  localparam logic [7:0] PTR_MARK = 8'hC0;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Input action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PARSE = 1'b1;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 2'd0,
    ERR_HOPS     = 2'd1,
    ERR_PAST_END = 2'd2,
    ERR_TOO_LONG = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT_REQ,
    ST_CNT_WAIT,
    ST_DOT,
    ST_PTR_REQ,
    ST_PTR_WAIT,
    ST_LBL_REQ,
    ST_LBL_WAIT,
    ST_TAIL,
    ST_Q_REQ,
    ST_Q_WAIT,
    ST_FINISH
  } state_e;

  // Sequencer to character packer
  typedef struct packed {
    logic       clear;
    logic       put;
    logic [7:0] ch;
  } pack_ctl_t;

  // Character packer to sequencer
  typedef struct packed {
    logic                   too_long;
    logic                   emit;
    logic [CHARS_W-1:0]     word;
    logic [CHARS_W-1:0]     chars;
    logic [LEN_W-1:0]       len;
  } pack_sts_t;

endpackage

@@ rtl/dqp_if.sv @@
// Valid/ready channel interfaces for parser input items and result items.
interface dqp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [dqp_pkg::OFFSET_W-1:0]  offset;
  logic [dqp_pkg::BYTE_W-1:0]    byte_value;

  modport source (output valid, action, offset, byte_value, input ready);
  modport sink   (input valid, action, offset, byte_value, output ready);
endinterface

interface dqp_out_if;
  logic                          valid;
  logic                          ready;
  logic [dqp_pkg::CHARS_W-1:0]   name_chars;
  logic [dqp_pkg::COUNT_W-1:0]   char_count;
  logic [dqp_pkg::QWORD_W-1:0]   query_type;
  logic [dqp_pkg::QWORD_W-1:0]   query_class;
  logic [dqp_pkg::NEXT_W-1:0]    next_pos;
  logic [dqp_pkg::ERR_W-1:0]     error;
  logic                          last;

  modport source (output valid, name_chars, char_count, query_type, query_class,
                  next_pos, error, last, input ready);
  modport sink   (input valid, name_chars, char_count, query_type, query_class,
                  next_pos, error, last, output ready);
endinterface

@@ rtl/dqp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dqp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/dqp_char_pack.sv @@
// Character packer: collects name characters into 8-byte words, counts length.
module dqp_char_pack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dqp_pkg::pack_ctl_t  ctl_i,
  output dqp_pkg::pack_sts_t  sts_o
);
  import dqp_pkg::*;

  logic [CHARS_W-1:0] buf_q, buf_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [CHARS_W-1:0] merged;
  logic [2:0]         lane;
  logic               too_long;
  logic               accept_char;
  logic               word_done;

  assign lane        = len_q[2:0];
  assign too_long    = len_q >= LEN_W'(MAX_NAME_CHARS);
  assign accept_char = ctl_i.put && !too_long;
  assign word_done   = accept_char && (lane == 3'd7);

  // Drop the new character into its byte lane
  always_comb begin
    merged = buf_q;
    for (int i = 0; i < 8; i++) begin
      if (lane == 3'(i)) begin
        merged[8*i +: 8] = ctl_i.ch;
      end
    end
  end

  always_comb begin
    buf_d = buf_q;
    len_d = len_q;
    if (ctl_i.clear) begin
      buf_d = '0;
      len_d = '0;
    end else if (accept_char) begin
      buf_d = word_done ? '0 : merged;
      len_d = len_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      len_q <= '0;
    end else begin
      buf_q <= buf_d;
      len_q <= len_d;
    end
  end

  assign sts_o.too_long = too_long;
  assign sts_o.emit     = word_done;
  assign sts_o.word     = merged;
  assign sts_o.chars    = buf_q;
  assign sts_o.len      = len_q;

endmodule

@@ rtl/dns_question_parser.sv @@
// Top level of the DNS question parser: sequencer, message store and result register.
// A load item (action 0) writes one byte into the 512-byte message store.
// A parse item (action 1) decodes the question at the given
// offset: labels become dotted text sent out eight characters per result,
// compression pointers are followed up to 16 hops, and a final result (last=1)
// carries the leftover characters, type, class, next position and an error
// code. The parse runs on the store's single read port with a registered read,
// so each byte read takes a request state and a wait state, and a parse also
// waits while a result has not yet been taken. The input is not ready while a
// parse is in progress. Store bytes read before they were written give
// undefined characters.
module dns_question_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  dqp_in_if.sink        in_i,
  dqp_out_if.source     out_o
);
  import dqp_pkg::*;

  state_e             state_q, state_d;
  logic [POS_W-1:0]   read_pos_q, read_pos_d;
  logic [POS_W-1:0]   resume_q, resume_d;
  logic [HOP_W-1:0]   hop_q, hop_d;
  logic               jumped_q, jumped_d;
  logic               dot_q, dot_d;
  logic               tail_q, tail_d;
  logic [7:0]         cnt_q, cnt_d;
  logic [7:0]         rem_q, rem_d;
  logic [31:0]        quad_q, quad_d;
  err_e               err_q, err_d;

  // Result register
  logic               out_valid_q;
  logic [CHARS_W-1:0] out_chars_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [QWORD_W-1:0] out_type_q, out_class_q;
  logic [NEXT_W-1:0]  out_next_q;
  err_e               out_err_q;
  logic               out_last_q;
  logic               load_final;
  logic [POS_W-1:0]   final_next;

  // Store ports
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [7:0]         ram_rdata;
  logic [POS_W-1:0]   in_off_ext;

  pack_ctl_t          pctl;
  pack_sts_t          psts;

  // Shared position unit: range check and increment
  logic               past_end;
  logic [POS_W-1:0]   pos_inc;
  logic               can_put;
  logic               in_acc;

  assign past_end = read_pos_q >= POS_W'(MSG_BYTES);
  assign pos_inc  = read_pos_q + POS_W'(1);
  assign can_put  = !out_valid_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_off_ext = POS_W'(in_i.offset);
  assign ram_waddr  = in_off_ext[ADDR_W-1:0];
  assign ram_we     = in_acc && (in_i.action == ACT_LOAD) &&
                      (in_off_ext < POS_W'(MSG_BYTES));

  dqp_ram #(
    .WIDTH (8),
    .DEPTH (MSG_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.byte_value),
    .re_i    (ram_re),
    .raddr_i (read_pos_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  dqp_char_pack u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pctl),
    .sts_o  (psts)
  );

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      read_pos_q <= '0;
      resume_q   <= '0;
      hop_q      <= '0;
      jumped_q   <= 1'b0;
      dot_q      <= 1'b0;
      tail_q     <= 1'b0;
      cnt_q      <= '0;
      rem_q      <= '0;
      quad_q     <= '0;
      err_q      <= ERR_OK;
    end else begin
      state_q    <= state_d;
      read_pos_q <= read_pos_d;
      resume_q   <= resume_d;
      hop_q      <= hop_d;
      jumped_q   <= jumped_d;
      dot_q      <= dot_d;
      tail_q     <= tail_d;
      cnt_q      <= cnt_d;
      rem_q      <= rem_d;
      quad_q     <= quad_d;
      err_q      <= err_d;
    end
  end

  // Next state and control
  always_comb begin
    state_d    = state_q;
    read_pos_d = read_pos_q;
    resume_d   = resume_q;
    hop_d      = hop_q;
    jumped_d   = jumped_q;
    dot_d      = dot_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quad_d     = quad_q;
    err_d      = err_q;
    ram_re     = 1'b0;
    pctl       = '0;
    load_final = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.action == ACT_PARSE)) begin
          read_pos_d = in_off_ext;
          resume_d   = '0;
          hop_d      = '0;
          jumped_d   = 1'b0;
          dot_d      = 1'b0;
          tail_d     = 1'b0;
          err_d      = ERR_OK;
          pctl.clear = 1'b1;
          state_d    = ST_CNT_REQ;
        end
      end

      // Count byte fetch
      ST_CNT_REQ: begin
        if (past_end) begin
          err_d   = ERR_PAST_END;
          state_d = ST_FINISH;
        end else begin
          ram_re     = 1'b1;
          read_pos_d = pos_inc;
          state_d    = ST_CNT_WAIT;
        end
      end

      ST_CNT_WAIT: begin
        cnt_d = ram_rdata;
        if (ram_rdata == 8'd0) begin
          state_d = ST_TAIL;
        end else if (dot_q) begin
          state_d = ST_DOT;
        end else if ((ram_rdata & PTR_MARK) == PTR_MARK) begin
          state_d = ST_PTR_REQ;
        end else begin
          rem_d   = ram_rdata;
          state_d = ST_LBL_REQ;
        end
      end

      // Separator before a label or pointer that follows a label
      ST_DOT: begin
        if (can_put) begin
          dot_d = 1'b0;
          if (psts.too_long) begin
            err_d   = ERR_TOO_LONG;
            state_d = ST_FINISH;
          end else begin
            pctl.put = 1'b1;
            pctl.ch  = DOT_CHAR;
            if ((cnt_q & PTR_MARK) == PTR_MARK) begin
              state_d = ST_PTR_REQ;
            end else begin
              rem_d   = cnt_q;
              state_d = ST_LBL_REQ;
            end
          end
        end
      end

      // Second pointer byte
      ST_PTR_REQ: begin
        if (past_end) begin
          err_d   = ERR_PAST_END;
          state_d = ST_FINISH;
        end else begin
          ram_re     = 1'b1;
          read_pos_d = pos_inc;
          state_d    = ST_PTR_WAIT;
        end
      end

      ST_PTR_WAIT: begin
        if (hop_q >= HOP_W'(MAX_HOPS)) begin
          err_d   = ERR_HOPS;
          state_d = ST_FINISH;
        end else begin
          if (!jumped_q) begin
            resume_d = read_pos_q;
            jumped_d = 1'b1;
          end
          hop_d      = hop_q + HOP_W'(1);
          read_pos_d = POS_W'({cnt_q[5:0], ram_rdata});
          state_d    = ST_CNT_REQ;
        end
      end

      // Label characters, one per read
      ST_LBL_REQ: begin
        if (past_end) begin
          err_d   = ERR_PAST_END;
          state_d = ST_FINISH;
        end else begin
          ram_re     = 1'b1;
          read_pos_d = pos_inc;
          rem_d      = rem_q - 8'd1;
          state_d    = ST_LBL_WAIT;
        end
      end

      ST_LBL_WAIT: begin
        if (can_put) begin
          if (psts.too_long) begin
            err_d   = ERR_TOO_LONG;
            state_d = ST_FINISH;
          end else begin
            pctl.put = 1'b1;
            pctl.ch  = ram_rdata;
            if (rem_q == 8'd0) begin
              dot_d   = 1'b1;
              state_d = ST_CNT_REQ;
            end else begin
              state_d = ST_LBL_REQ;
            end
          end
        end
      end

      // Type and class follow the top-level name
      ST_TAIL: begin
        tail_d     = 1'b1;
        read_pos_d = jumped_q ? resume_q : read_pos_q;
        rem_d      = '0;
        state_d    = ST_Q_REQ;
      end

      ST_Q_REQ: begin
        if (past_end) begin
          err_d   = ERR_PAST_END;
          state_d = ST_FINISH;
        end else begin
          ram_re     = 1'b1;
          read_pos_d = pos_inc;
          state_d    = ST_Q_WAIT;
        end
      end

      ST_Q_WAIT: begin
        quad_d = {quad_q[23:0], ram_rdata};
        rem_d  = rem_q + 8'd1;
        if (rem_q == 8'd3) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_Q_REQ;
        end
      end

      // Final result
      ST_FINISH: begin
        if (can_put) begin
          load_final = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Position reported after the question, saturated at the store size
  always_comb begin
    if (err_q == ERR_PAST_END && tail_q) begin
      final_next = POS_W'(MSG_BYTES);
    end else if (err_q == ERR_OK || tail_q) begin
      final_next = read_pos_q;
    end else begin
      final_next = jumped_q ? resume_q : read_pos_q;
    end
    if (final_next > POS_W'(MSG_BYTES)) begin
      final_next = POS_W'(MSG_BYTES);
    end
  end

  // Result register, loaded by a full word or by the final result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_chars_q <= '0;
      out_count_q <= '0;
      out_type_q  <= '0;
      out_class_q <= '0;
      out_next_q  <= '0;
      out_err_q   <= ERR_OK;
      out_last_q  <= 1'b0;
    end else begin
      if (psts.emit) begin
        out_valid_q <= 1'b1;
        out_chars_q <= psts.word;
        out_count_q <= COUNT_W'(8);
        out_type_q  <= '0;
        out_class_q <= '0;
        out_next_q  <= '0;
        out_err_q   <= ERR_OK;
        out_last_q  <= 1'b0;
      end else if (load_final) begin
        out_valid_q <= 1'b1;
        out_chars_q <= psts.chars;
        out_count_q <= COUNT_W'(psts.len[2:0]);
        out_type_q  <= (err_q == ERR_OK) ? quad_q[31:16] : '0;
        out_class_q <= (err_q == ERR_OK) ? quad_q[15:0] : '0;
        out_next_q  <= final_next[NEXT_W-1:0];
        out_err_q   <= err_q;
        out_last_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.name_chars  = out_chars_q;
  assign out_o.char_count  = out_count_q;
  assign out_o.query_type  = out_type_q;
  assign out_o.query_class = out_class_q;
  assign out_o.next_pos    = out_next_q;
  assign out_o.error       = out_err_q;
  assign out_o.last        = out_last_q;

endmodule
